@@ rtl/datetime_check_bcd_pack_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the date-time check and BCD pack unit.
// ----------------------------------------------------------------------------
`ifndef DATETIME_CHECK_BCD_PACK_UNIT_MACROS_SVH
`define DATETIME_CHECK_BCD_PACK_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DTBCD_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DTBCD_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

@@ rtl/dtbcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dtbcd_pkg
// Types, codes, limits and helper functions of the date-time check unit.
// ----------------------------------------------------------------------------
package dtbcd_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [7:0] MIN_FRAME_LEN   = 8'd5;
	localparam logic [2:0] OUT_LEN         = 3'd5;
	localparam logic [7:0] MINUTE_MAX      = 8'd59;
	localparam logic [7:0] HOUR_MAX        = 8'd23;
	localparam logic [6:0] YEAR_OFFSET_MAX = 7'd99;

	localparam logic [4:0] DAYS_LONG  = 5'd31;
	localparam logic [4:0] DAYS_SHORT = 5'd30;
	localparam logic [4:0] DAYS_FEB_L = 5'd29;
	localparam logic [4:0] DAYS_FEB   = 5'd28;

	typedef struct packed {
		logic [7:0] frame_length;
		logic [6:0] year_offset;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
		logic [7:0] minute;
	} dtbcd_rec_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] out_length;
		logic [7:0] bcd_minute;
		logic [7:0] bcd_hour;
		logic [7:0] bcd_day;
		logic [7:0] bcd_month;
		logic [7:0] bcd_year;
	} dtbcd_result_t;

	// two-digit packed BCD; tens by multiply-shift, exact for 0..127
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	// zero for a month outside 1..12
	function automatic logic [4:0] month_days(input logic [7:0] m, input logic leap);
		logic [4:0] d;
		unique case (m)
			8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: d = DAYS_LONG;
			8'd4, 8'd6, 8'd9, 8'd11:                     d = DAYS_SHORT;
			8'd2:                                        d = leap ? DAYS_FEB_L : DAYS_FEB;
			default:                                     d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/dtbcd_eval.sv @@
// ----------------------------------------------------------------------------
// dtbcd_eval
// Checks one date-time record and packs the valid fields as BCD bytes.
// ----------------------------------------------------------------------------
module dtbcd_eval import dtbcd_pkg::*; (
	input  dtbcd_rec_t    rec,
	output dtbcd_result_t res
);

	logic       short_frame;
	logic       leap;
	logic [4:0] dim;
	logic       in_range;

	assign short_frame = rec.frame_length < MIN_FRAME_LEN;
	// 2000 counts as leap; no century year other than 2000 lies in 0..99
	assign leap        = rec.year_offset[1:0] == 2'b00;
	assign dim         = month_days(rec.month, leap);
	assign in_range    = (rec.minute <= MINUTE_MAX) && (rec.hour <= HOUR_MAX) &&
		(rec.year_offset <= YEAR_OFFSET_MAX) && (dim != 5'd0) &&
		(rec.day != 8'd0) && (rec.day <= {3'b000, dim});

	always_comb begin
		res = '0;
		if (short_frame) begin
			res.status = ST_SHORT;
		end else if (!in_range) begin
			res.status = ST_RANGE;
		end else begin
			res.status     = ST_OK;
			res.out_length = OUT_LEN;
			res.bcd_minute = to_bcd(rec.minute[6:0]);
			res.bcd_hour   = to_bcd(rec.hour[6:0]);
			res.bcd_day    = to_bcd(rec.day[6:0]);
			res.bcd_month  = to_bcd(rec.month[6:0]);
			res.bcd_year   = to_bcd(rec.year_offset);
		end
	end

endmodule

@@ rtl/datetime_check_bcd_pack_unit.sv @@
// ----------------------------------------------------------------------------
// datetime_check_bcd_pack_unit
// Validates binary date-time records and returns them as packed BCD bytes.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   req_valid/req_ready    frame_length year_offset month day hour minute
//  response  rsp_valid/rsp_ready    status out_length bcd_minute .. bcd_year
//
//  One record per cycle while the response is taken; input register then
//  result register with the check and BCD logic between them.
//  Reset clears both stage valid bits; no record is held across reset.
//  A stalled response holds the result register and backs up into the input
//  register; req_ready stays high while either stage can still advance.
// ----------------------------------------------------------------------------
module datetime_check_bcd_pack_unit import dtbcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [7:0] frame_length,
	input  logic [6:0] year_offset,
	input  logic [7:0] month,
	input  logic [7:0] day,
	input  logic [7:0] hour,
	input  logic [7:0] minute,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [1:0] status,
	output logic [2:0] out_length,
	output logic [7:0] bcd_minute,
	output logic [7:0] bcd_hour,
	output logic [7:0] bcd_day,
	output logic [7:0] bcd_month,
	output logic [7:0] bcd_year
);

	logic          valid_s1;
	logic          valid_s2;
	dtbcd_rec_t    rec_s1;
	dtbcd_result_t res_comb;
	dtbcd_result_t res_s2;
	logic          adv_s1;
	logic          adv_s2;

	assign adv_s2    = !valid_s2 || rsp_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= req_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			rec_s1 <= '{frame_length: frame_length, year_offset: year_offset,
				month: month, day: day, hour: hour, minute: minute};
		end
		if (adv_s2 && valid_s1) res_s2 <= res_comb;
	end

	dtbcd_eval u_eval (
		.rec (rec_s1),
		.res (res_comb)
	);

	assign rsp_valid  = valid_s2;
	assign status     = res_s2.status;
	assign out_length = res_s2.out_length;
	assign bcd_minute = res_s2.bcd_minute;
	assign bcd_hour   = res_s2.bcd_hour;
	assign bcd_day    = res_s2.bcd_day;
	assign bcd_month  = res_s2.bcd_month;
	assign bcd_year   = res_s2.bcd_year;

endmodule

@@ rtl/dtbcd_checker.sv @@
// ----------------------------------------------------------------------------
// dtbcd_checker
// Port-level checks of the date-time check unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "datetime_check_bcd_pack_unit_macros.svh"

module dtbcd_checker import dtbcd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] status,
	input logic [2:0] out_length,
	input logic [7:0] bcd_minute,
	input logic [7:0] bcd_hour,
	input logic [7:0] bcd_day,
	input logic [7:0] bcd_month,
	input logic [7:0] bcd_year
);

	`DTBCD_ASSERT_NOW(a_ok_len, rsp_valid && status == ST_OK, out_length == OUT_LEN, "ok result without length 5")
	`DTBCD_ASSERT_NOW(a_err_zero, rsp_valid && status != ST_OK, out_length == 3'd0 && bcd_minute == 8'd0 && bcd_hour == 8'd0 && bcd_day == 8'd0 && bcd_month == 8'd0 && bcd_year == 8'd0, "error result with nonzero payload")
	`DTBCD_ASSERT_NOW(a_ok_bcd, rsp_valid && status == ST_OK, bcd_minute <= 8'h59 && bcd_hour <= 8'h23 && bcd_day != 8'h00 && bcd_day <= 8'h31 && bcd_month != 8'h00 && bcd_month <= 8'h12, "ok result outside BCD range")
	`DTBCD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(bcd_day), "stalled response changed")

endmodule

bind datetime_check_bcd_pack_unit dtbcd_checker u_checker (.*);
